/* design/sdl_pkg.sv */
// sorted deadline list: shared types and codes
// used by the channel interfaces and the top level; no dependencies
package sdl_pkg;

   localparam int HANDLE_BITS  = 4;
   localparam int HANDLE_COUNT = 1 << HANDLE_BITS;
   localparam int KEY_IN_BITS  = 32;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_PRESENT = 2'd2,
      ST_ABSENT  = 2'd3
   } status_type;

endpackage

/* design/sdl_channels.sv */
// sorted deadline list: request and response channel interfaces
// depends on sdl_pkg
interface sdl_req_if
   import sdl_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic [1:0]              op;
   logic [HANDLE_BITS-1:0]  handle;
   logic [KEY_IN_BITS-1:0]  key;

   modport source (output valid, op, handle, key, input ready);
   modport sink   (input valid, op, handle, key, output ready);
endinterface

interface sdl_rsp_if
   import sdl_pkg::*;
   #(parameter int COUNT_BITS = 5)
   ();
   logic                    valid;
   logic                    ready;
   logic [1:0]              status;
   logic [COUNT_BITS-1:0]   count;
   logic                    head_valid;
   logic [HANDLE_BITS-1:0]  head_handle;
   logic [KEY_IN_BITS-1:0]  head_key;

   modport source (output valid, status, count, head_valid, head_handle, head_key,
                   input ready);
   modport sink   (input valid, status, count, head_valid, head_handle, head_key,
                   output ready);
endinterface

/* design/sorted_deadline_list.sv */
// sorted deadline list: top level with sequencer, slot RAM and presence bits
// depends on sdl_pkg, sdl_channels (sdl_req_if, sdl_rsp_if) and sdl_ram
//
// Keeps up to ENTRIES handles in ascending key order in a slot RAM, one
// entry per word. An insert walks from the tail towards the head, moving
// each entry whose key is not below the new one up by a slot, so a new
// entry goes ahead of equal keys; an all-ones key is written straight at
// the tail when KEY_BITS is at most KEY_IN_BITS. A remove walks from the
// head, finds the handle and moves every later entry down by a slot. Each
// walk step is a RAM read in a read state and then a key or handle compare
// in an evaluate state, because the RAM read is registered. A remove always
// walks the whole list; a tail insert, clear, unused op and rejected
// requests skip the walk. The block takes one request at a time; a finished
// response waits in its output register while the next request is
// accepted. The rsp_ch interface must be instantiated with COUNT_BITS equal
// to $clog2(ENTRIES + 1).
module sorted_deadline_list
   import sdl_pkg::*;
#(
   parameter int ENTRIES  = 16,
   parameter int KEY_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   sdl_req_if.sink    req_ch,
   sdl_rsp_if.source  rsp_ch
);

   localparam int AW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int KW = (KEY_BITS < KEY_IN_BITS) ? KEY_BITS : KEY_IN_BITS;
   localparam int DW = HANDLE_BITS + KW;
   localparam logic [CW-1:0] FULL_COUNT = CW'(ENTRIES);
   localparam bit TAIL_KEY_OK = (KEY_BITS <= KEY_IN_BITS);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_INS_RD = 7'b0000010,
      S_INS_EV = 7'b0000100,
      S_RM_RD  = 7'b0001000,
      S_RM_EV  = 7'b0010000,
      S_HD_RD  = 7'b0100000,
      S_HD_EV  = 7'b1000000
   } state_type;

   state_type                state_ff, state_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [CW-1:0]            idx_ff, idx_in;
   logic                     found_ff, found_in;
   logic [HANDLE_COUNT-1:0]  present_ff, present_in;
   logic [1:0]               status_ff, status_in;
   logic [HANDLE_BITS-1:0]   h_ff, h_in;
   logic [KW-1:0]            k_ff, k_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [1:0]               rsp_status_ff;
   logic [CW-1:0]            rsp_count_ff;
   logic                     rsp_head_valid_ff;
   logic [HANDLE_BITS-1:0]   rsp_head_handle_ff;
   logic [KEY_IN_BITS-1:0]   rsp_head_key_ff;
   logic                     rsp_load;

   logic                     wr_en, rd_en;
   logic [AW-1:0]            wr_addr, rd_addr;
   logic [DW-1:0]            wr_data, rd_data;
   logic [KW-1:0]            rd_key;
   logic [HANDLE_BITS-1:0]   rd_handle;
   logic [KW-1:0]            req_key;
   logic                     req_tail;
   logic                     key_ge, handle_eq;

   sdl_ram #(.WIDTH(DW), .DEPTH(ENTRIES)) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_handle = rd_data[DW-1 -: HANDLE_BITS];
   assign rd_key    = rd_data[KW-1:0];
   assign req_key   = req_ch.key[KW-1:0];
   assign req_tail  = TAIL_KEY_OK && (&req_key);

   // key and handle comparators
   assign key_ge    = (rd_key >= k_ff);
   assign handle_eq = (rd_handle == h_ff);

   assign req_ch.ready = (state_ff == S_IDLE);
   assign rsp_load     = (state_ff == S_HD_EV) && (!rsp_valid_ff || rsp_ch.ready);

   // sequencer
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      found_in   = found_ff;
      present_in = present_ff;
      status_in  = status_ff;
      h_in       = h_ff;
      k_in       = k_ff;
      wr_en      = 1'b0;
      wr_addr    = idx_ff[AW-1:0];
      wr_data    = {h_ff, k_ff};
      rd_en      = 1'b0;
      rd_addr    = idx_ff[AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               h_in      = req_ch.handle;
               k_in      = req_key;
               status_in = ST_OK;
               idx_in    = count_ff;
               found_in  = 1'b0;
               state_in  = S_HD_RD;
               unique case (req_ch.op)
                  OP_INSERT: begin
                     if (present_ff[req_ch.handle]) begin
                        status_in = ST_PRESENT;
                     end else if (count_ff >= FULL_COUNT) begin
                        status_in = ST_FULL;
                     end else if (req_tail) begin
                        wr_en      = 1'b1;
                        wr_addr    = count_ff[AW-1:0];
                        wr_data    = {req_ch.handle, req_key};
                        count_in   = count_ff + 1'b1;
                        present_in[req_ch.handle] = 1'b1;
                     end else begin
                        state_in = S_INS_RD;
                     end
                  end
                  OP_REMOVE: begin
                     if (!present_ff[req_ch.handle]) begin
                        status_in = ST_ABSENT;
                     end else begin
                        idx_in   = '0;
                        state_in = S_RM_RD;
                     end
                  end
                  OP_CLEAR: begin
                     count_in   = '0;
                     present_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         // walk from the tail, reading the entry below the hole
         S_INS_RD: begin
            if (idx_ff == '0) begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
               present_in[h_ff] = 1'b1;
               state_in = S_HD_RD;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = AW'(idx_ff - 1'b1);
               state_in = S_INS_EV;
            end
         end
         // move the entry up, or drop the new one into the hole
         S_INS_EV: begin
            wr_en = 1'b1;
            if (key_ge) begin
               wr_data  = rd_data;
               idx_in   = idx_ff - 1'b1;
               state_in = S_INS_RD;
            end else begin
               count_in = count_ff + 1'b1;
               present_in[h_ff] = 1'b1;
               state_in = S_HD_RD;
            end
         end
         // walk from the head
         S_RM_RD: begin
            if (idx_ff == count_ff) begin
               if (found_ff) begin
                  count_in = count_ff - 1'b1;
               end
               present_in[h_ff] = 1'b0;
               state_in = S_HD_RD;
            end else begin
               rd_en    = 1'b1;
               state_in = S_RM_EV;
            end
         end
         // after the match, move each entry down a slot
         S_RM_EV: begin
            if (found_ff) begin
               wr_en   = 1'b1;
               wr_addr = AW'(idx_ff - 1'b1);
               wr_data = rd_data;
            end else if (handle_eq) begin
               found_in = 1'b1;
            end
            idx_in   = idx_ff + 1'b1;
            state_in = S_RM_RD;
         end
         S_HD_RD: begin
            rd_en    = 1'b1;
            rd_addr  = '0;
            state_in = S_HD_EV;
         end
         // wait for the output register to be free
         S_HD_EV: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // response valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         present_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         present_ff   <= present_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      found_ff  <= found_in;
      status_ff <= status_in;
      h_ff      <= h_in;
      k_ff      <= k_in;
   end

   // response payload
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_count_ff  <= count_ff;
         if (count_ff == '0) begin
            rsp_head_valid_ff  <= 1'b0;
            rsp_head_handle_ff <= '0;
            rsp_head_key_ff    <= '0;
         end else begin
            rsp_head_valid_ff  <= 1'b1;
            rsp_head_handle_ff <= rd_handle;
            rsp_head_key_ff    <= KEY_IN_BITS'(rd_key);
         end
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.count       = rsp_count_ff;
   assign rsp_ch.head_valid  = rsp_head_valid_ff;
   assign rsp_ch.head_handle = rsp_head_handle_ff;
   assign rsp_ch.head_key    = rsp_head_key_ff;

endmodule

/* design/sdl_ram.sv */
// sorted deadline list: generic simple dual-port RAM, registered read
// no dependencies
module sdl_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, holds its data while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
